FILE: rtl/core/bts_pkg.sv
// Shared types, constants and the fixed-point lerp for the bilinear texture sampler.
// Used by every module under rtl/core except bts_ram; depends on nothing.
package bts_pkg;

  localparam int COORD_W    = 17;
  localparam int FRAC_W     = 16;
  localparam int SIZE_W     = 9;
  localparam int ADDR_MAX_W = 20;
  localparam int IN_CH_W    = 16;
  localparam int CH_MAX_W   = 24;
  localparam int ACC_W      = CH_MAX_W + COORD_W + 1;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [COORD_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'b1;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // Neighbor order: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1).
  // A write uses slot 0 for its address.
  typedef struct packed {
    op_t                             op;
    logic [3:0][ADDR_MAX_W-1:0]      addr;
    logic [3:0]                      oob;
    logic [FRAC_W-1:0]               tx;
    logic [FRAC_W-1:0]               ty;
    logic [2:0][IN_CH_W-1:0]         data;
  } entry_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               empty;
  } q_status_t;

  // (a * (1.0 - t) + b * t) >> 16, truncated
  function automatic logic [CH_MAX_W-1:0] lerp(input logic [CH_MAX_W-1:0] a,
                                               input logic [CH_MAX_W-1:0] b,
                                               input logic [FRAC_W-1:0]   t);
    logic [ACC_W-1:0] acc;
    acc = ACC_W'(a) * ACC_W'(ONE_Q16 - {1'b0, t}) + ACC_W'(b) * ACC_W'(t);
    return acc[FRAC_W +: CH_MAX_W];
  endfunction

endpackage

FILE: rtl/core/bilinear_texture_sampler.sv
// Bilinear texture sampler, top level: config registers, front end, queue, back end.
// Depends on bts_pkg, bts_front, bts_queue, bts_back and bts_ram.
//
// Accepts one item per clock while in_stall is low. A write item (func = 0)
// stores one RGB texel at texel_index and gives no result; a sample item
// (func = 1) gives one filtered RGB result through two front-end address
// stages, the queue, memory read, horizontal lerp and vertical lerp/output
// register. The four neighbor texels come from four copies of the texel
// memory that all take every write, so all four are read at once. Writes and
// samples stay in order: a sample sees every write accepted before it. Texture
// size is set by tex_width (index 0) and tex_height (index 1); change them only
// while no item is in flight. Reading a texel never written returns garbage.
module bilinear_texture_sampler #(
  parameter int TEX_DEPTH    = 65536,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bts_pkg::SIZE_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [15:0]                       texel_index,
  input  logic [15:0]                       red_in,
  input  logic [15:0]                       green_in,
  input  logic [15:0]                       blue_in,
  input  logic [16:0]                       u_coord,
  input  logic [16:0]                       v_coord,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [15:0]                       red,
  output logic [15:0]                       green,
  output logic [15:0]                       blue
);

  logic [bts_pkg::SIZE_W-1:0] tex_width, tex_height;
  logic                       q_push, q_pop;
  bts_pkg::entry_t            push_entry, pop_entry;
  bts_pkg::q_status_t         q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= bts_pkg::SIZE_W'(256);
      tex_height <= bts_pkg::SIZE_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bts_pkg::REG_TEX_WIDTH:  tex_width  <= cfg_data;
        bts_pkg::REG_TEX_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bts_front #(
    .TEX_DEPTH(TEX_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .texel_index(texel_index),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .u_coord    (u_coord),
    .v_coord    (v_coord),
    .tex_width  (tex_width),
    .tex_height (tex_height),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_entry (push_entry)
  );

  bts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(push_entry),
    .pop       (q_pop),
    .pop_entry (pop_entry),
    .q_stat    (q_stat)
  );

  bts_back #(
    .TEX_DEPTH   (TEX_DEPTH),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .pop_entry(pop_entry),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

  // front-end credit must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && !q_pop && q_stat.count == bts_pkg::Q_CNT_W'(bts_pkg::Q_DEPTH)))
    else $error("queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= bts_pkg::Q_CNT_W'(bts_pkg::Q_DEPTH))
    else $error("queue count out of range");

  // an accepted item implies credit was available in the queue
  a_credit: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (q_stat.count < bts_pkg::Q_CNT_W'(bts_pkg::Q_DEPTH)))
    else $error("item accepted without queue credit");

endmodule

FILE: rtl/core/bts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/bts_front.sv
// Front end: accepts items, saturates and scales coordinates, forms the four
// texel addresses and pushes classified entries to the queue. Uses bts_pkg.
module bts_front #(
  parameter int TEX_DEPTH = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [15:0]                       texel_index,
  input  logic [15:0]                       red_in,
  input  logic [15:0]                       green_in,
  input  logic [15:0]                       blue_in,
  input  logic [16:0]                       u_coord,
  input  logic [16:0]                       v_coord,
  input  logic [bts_pkg::SIZE_W-1:0]        tex_width,
  input  logic [bts_pkg::SIZE_W-1:0]        tex_height,
  input  bts_pkg::q_status_t                q_stat,
  output logic                              push,
  output bts_pkg::entry_t                   push_entry
);

  localparam int SW = bts_pkg::SIZE_W;
  localparam int PW = bts_pkg::COORD_W + SW;
  localparam int AM = bts_pkg::ADDR_MAX_W;

  logic            accept;
  logic [SW-1:0]   w_eff, h_eff;
  logic [16:0]     cu, cv;

  logic            v1;
  bts_pkg::op_t    op1;
  logic [15:0]     idx1;
  logic [2:0][15:0] data1;
  logic [PW-1:0]   su1, sv1;
  logic [SW-1:0]   w1, h1;

  logic [SW-1:0]   x0, x1, y0, y1, wm1, hm1;
  logic [2*SW-1:0] row0, row1;
  logic [3:0][AM-1:0] addr;
  bts_pkg::entry_t entry_next;

  logic            v2;

  assign in_stall = (4'(q_stat.count) + 4'(v1) + 4'(v2)) >= 4'(bts_pkg::Q_DEPTH);
  assign accept   = in_valid && !in_stall;

  assign w_eff = (tex_width == '0) ? SW'(1) : tex_width;
  assign h_eff = (tex_height == '0) ? SW'(1) : tex_height;
  assign cu    = (u_coord > bts_pkg::ONE_Q16) ? bts_pkg::ONE_Q16 : u_coord;
  assign cv    = (v_coord > bts_pkg::ONE_Q16) ? bts_pkg::ONE_Q16 : v_coord;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    if (accept) begin
      op1   <= func ? bts_pkg::OP_SAMPLE : bts_pkg::OP_WRITE;
      idx1  <= texel_index;
      data1 <= {blue_in, green_in, red_in};
      su1   <= PW'(cu) * PW'(w_eff - SW'(1));
      sv1   <= PW'(cv) * PW'(h_eff - SW'(1));
      w1    <= w_eff;
      h1    <= h_eff;
    end
  end

  always_comb begin
    wm1 = w1 - SW'(1);
    hm1 = h1 - SW'(1);
    x0  = su1[bts_pkg::FRAC_W +: SW];
    y0  = sv1[bts_pkg::FRAC_W +: SW];
    // far neighbor clamps to the last column / row
    x1  = (({1'b0, x0} + (SW+1)'(1)) < {1'b0, wm1}) ? x0 + SW'(1) : wm1;
    y1  = (({1'b0, y0} + (SW+1)'(1)) < {1'b0, hm1}) ? y0 + SW'(1) : hm1;
    row0 = (2*SW)'(y0) * (2*SW)'(w1);
    row1 = (2*SW)'(y1) * (2*SW)'(w1);
    if (op1 == bts_pkg::OP_SAMPLE) begin
      addr[0] = AM'(row0) + AM'(x0);
      addr[1] = AM'(row0) + AM'(x1);
      addr[2] = AM'(row1) + AM'(x0);
      addr[3] = AM'(row1) + AM'(x1);
    end else begin
      addr    = '0;
      addr[0] = AM'(idx1);
    end
    entry_next.op   = op1;
    entry_next.addr = addr;
    for (int k = 0; k < 4; k++) begin
      entry_next.oob[k] = {1'b0, addr[k]} >= (AM+1)'(TEX_DEPTH);
    end
    entry_next.tx   = su1[bts_pkg::FRAC_W-1:0];
    entry_next.ty   = sv1[bts_pkg::FRAC_W-1:0];
    entry_next.data = data1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    if (v1) begin
      push_entry <= entry_next;
    end
  end

  assign push = v2;

endmodule

FILE: rtl/core/bts_queue.sv
// Four-entry queue between the front end and the back end.
// Uses bts_pkg for the entry and status types.
module bts_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bts_pkg::entry_t    push_entry,
  input  logic               pop,
  output bts_pkg::entry_t    pop_entry,
  output bts_pkg::q_status_t q_stat
);

  bts_pkg::entry_t                 mem [bts_pkg::Q_DEPTH];
  logic [bts_pkg::Q_PTR_W-1:0]     wp, rp;
  logic [bts_pkg::Q_CNT_W-1:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + bts_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rp <= rp + bts_pkg::Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + bts_pkg::Q_CNT_W'(1);
        2'b01:   count <= count - bts_pkg::Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
    if (push) begin
      mem[wp] <= push_entry;
    end
  end

  assign pop_entry    = mem[rp];
  assign q_stat.count = count;
  assign q_stat.empty = (count == '0);

endmodule

FILE: rtl/core/bts_back.sv
// Back end: texel memory (four read copies), horizontal then vertical lerp,
// output register. Uses bts_pkg and bts_ram.
module bts_back #(
  parameter int TEX_DEPTH    = 65536,
  parameter int CHANNEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  bts_pkg::q_status_t q_stat,
  output logic               pop,
  input  bts_pkg::entry_t    pop_entry,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        red,
  output logic [15:0]        green,
  output logic [15:0]        blue
);

  localparam int AW = $clog2(TEX_DEPTH);
  localparam int CB = CHANNEL_BITS;
  localparam int DW = 3 * CB;
  localparam int CW = bts_pkg::CH_MAX_W;

  logic          adv, we;
  logic [DW-1:0] wdata;
  logic [DW-1:0] rdata [4];

  logic                           v1, v2;
  logic [bts_pkg::FRAC_W-1:0]     tx1, ty1, ty2;
  logic [3:0]                     oob1;
  logic [3:0][2:0][CW-1:0]        texel;
  logic [2:0][CW-1:0]             top_next, bot_next, top2, bot2;
  logic [2:0][CW-1:0]             pix;

  assign adv = !out_valid || !out_stall;
  assign pop = adv && !q_stat.empty;
  assign we  = pop && (pop_entry.op == bts_pkg::OP_WRITE) && !pop_entry.oob[0];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      wdata[ch*CB +: CB] = CB'(pop_entry.data[ch]);
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    bts_ram #(
      .WIDTH(DW),
      .DEPTH(TEX_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(AW'(pop_entry.addr[0])),
      .wdata(wdata),
      .re   (adv),
      .raddr(AW'(pop_entry.addr[k])),
      .rdata(rdata[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pop && (pop_entry.op == bts_pkg::OP_SAMPLE);
    end
    if (adv) begin
      tx1  <= pop_entry.tx;
      ty1  <= pop_entry.ty;
      oob1 <= pop_entry.oob;
    end
  end

  // out-of-range texels read as zero
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        texel[k][ch] = oob1[k] ? '0 : CW'(rdata[k][ch*CB +: CB]);
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      top_next[ch] = bts_pkg::lerp(texel[0][ch], texel[1][ch], tx1);
      bot_next[ch] = bts_pkg::lerp(texel[2][ch], texel[3][ch], tx1);
      pix[ch]      = bts_pkg::lerp(top2[ch], bot2[ch], ty2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v2        <= v1;
      out_valid <= v2;
    end
    if (adv) begin
      top2  <= top_next;
      bot2  <= bot_next;
      ty2   <= ty1;
      red   <= 16'(pix[0]);
      green <= 16'(pix[1]);
      blue  <= 16'(pix[2]);
    end
  end

endmodule

FILE: dv/tb.sv
// Self-checking testbench for bilinear_texture_sampler: texel writes, bilinear samples.
// Depends on bts_pkg and the sampler RTL; keeps its own shadow texture and filter predictor.
module tb;

  typedef struct {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } rgb_t;

  typedef struct {
    bts_pkg::op_t op;
    logic [15:0] idx;
    rgb_t        pix;
    logic [16:0] u;
    logic [16:0] v;
    bit          typed;
    rgb_t        want;
  } row_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [bts_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bts_pkg::SIZE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic              func;
  logic [15:0]       texel_index;
  logic [15:0]       red_in;
  logic [15:0]       green_in;
  logic [15:0]       blue_in;
  logic [16:0]       u_coord;
  logic [16:0]       v_coord;
  logic              out_valid;
  logic              out_stall;
  logic [15:0]       red;
  logic [15:0]       green;
  logic [15:0]       blue;

  logic [47:0]       shadow_tex [0:65535];
  bit                texel_set [0:65535];
  logic [8:0]        width_reg;
  logic [8:0]        height_reg;
  rgb_t              pending_rgb[$];
  int                errors;
  bit                quiet;

  bilinear_texture_sampler uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .texel_index(texel_index),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .u_coord(u_coord), .v_coord(v_coord),
    .out_valid(out_valid), .out_stall(out_stall), .red(red), .green(green), .blue(blue)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 500000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  // Cell, clamped neighbor and fraction along one axis
  function automatic void split_axis(logic [16:0] c, logic [8:0] size_reg,
                                     output longint i0, output longint i1,
                                     output longint frac);
    longint sz;
    longint cc;
    longint scaled;
    sz = (size_reg == 0) ? 1 : size_reg;
    cc = (c > 17'h10000) ? 65536 : c;
    scaled = cc * (sz - 1);
    i0 = scaled >> 16;
    frac = scaled & 16'hFFFF;
    i1 = (i0 + 1 < sz - 1) ? i0 + 1 : sz - 1;
  endfunction

  // Addresses of the four neighbors, order 00, 10, 01, 11
  function automatic void corner_addrs(logic [16:0] u, logic [16:0] v,
                                       output longint a[4], output longint tx,
                                       output longint ty);
    longint x0, x1, y0, y1, w;
    split_axis(u, width_reg, x0, x1, tx);
    split_axis(v, height_reg, y0, y1, ty);
    w = (width_reg == 0) ? 1 : width_reg;
    a[0] = y0 * w + x0;
    a[1] = y0 * w + x1;
    a[2] = y1 * w + x0;
    a[3] = y1 * w + x1;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return (a * (65536 - t) + b * t) >> 16;
  endfunction

  function automatic rgb_t filter_rgb(logic [16:0] u, logic [16:0] v);
    longint a[4];
    longint tx, ty, top, bot;
    longint c[4];
    logic [15:0] ch[3];
    rgb_t res;
    corner_addrs(u, v, a, tx, ty);
    for (int k = 0; k < 3; k++) begin
      for (int n = 0; n < 4; n++)
        c[n] = (a[n] >= 65536) ? 0 : shadow_tex[a[n]][47 - 16*k -: 16];
      top = blend(c[0], c[1], tx);
      bot = blend(c[2], c[3], tx);
      ch[k] = 16'(blend(top, bot, ty));
    end
    res.r = ch[0];
    res.g = ch[1];
    res.b = ch[2];
    return res;
  endfunction

  task automatic send_item(bts_pkg::op_t op, logic [15:0] idx, rgb_t pix, logic [16:0] u,
                           logic [16:0] v, bit typed, rgb_t want);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    func        = op;
    texel_index = idx;
    red_in      = pix.r;
    green_in    = pix.g;
    blue_in     = pix.b;
    u_coord     = u;
    v_coord     = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == bts_pkg::OP_WRITE) begin
      shadow_tex[idx] = {pix.r, pix.g, pix.b};
      texel_set[idx]  = 1'b1;
    end else begin
      pending_rgb.push_back(typed ? want : filter_rgb(u, v));
    end
  endtask

  function automatic rgb_t rand_rgb();
    rgb_t p;
    p.r = 16'($urandom);
    p.g = 16'($urandom);
    p.b = 16'($urandom);
    return p;
  endfunction

  // Fill any never-written in-range neighbor before a sample can read it
  task automatic sample_at(logic [16:0] u, logic [16:0] v, bit typed, rgb_t want);
    longint a[4];
    longint tx, ty;
    corner_addrs(u, v, a, tx, ty);
    for (int n = 0; n < 4; n++)
      if (a[n] < 65536 && !texel_set[a[n]])
        send_item(bts_pkg::OP_WRITE, 16'(a[n]), rand_rgb(), 17'($urandom),
                  17'($urandom), 0, want);
    send_item(bts_pkg::OP_SAMPLE, 16'($urandom), rand_rgb(), u, v, typed, want);
  endtask

  task automatic set_reg(logic [bts_pkg::CFG_IDX_W-1:0] idx, logic [8:0] value);
    @(negedge clk);
    in_valid  = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == bts_pkg::REG_TEX_WIDTH) width_reg = value;
    else height_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [16:0] rand_coord();
    case ($urandom_range(9))
      0: return 17'h00000;
      1: return 17'h10000;
      2: return 17'($urandom_range(17'h1FFFF, 17'h10001));
      default: return 17'($urandom_range(17'h10000));
    endcase
  endfunction

  always @(negedge clk) begin
    out_stall <= (!quiet && $urandom_range(99) < 8);
  end

  always @(posedge clk) begin
    rgb_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rgb.size() == 0) begin
        $display("%0t: result with no sample outstanding", $time);
        errors++;
      end else begin
        want = pending_rgb.pop_front();
        if (red !== want.r)   report_mismatch("red", red, want.r);
        if (green !== want.g) report_mismatch("green", green, want.g);
        if (blue !== want.b)  report_mismatch("blue", blue, want.b);
      end
    end
  end

  initial begin
    row_t dir_rows[$];
    row_t row;
    rgb_t none;
    logic [8:0] sizes[$];
    rgb_t pix;
    errors = 0;
    quiet = 1'b0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    none = '{16'h0, 16'h0, 16'h0};
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = bts_pkg::REG_TEX_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    func = bts_pkg::OP_WRITE;
    texel_index = '0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    u_coord = '0;
    v_coord = '0;
    out_stall = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows at the reset size of 256 x 256
    dir_rows = '{
      '{bts_pkg::OP_WRITE, 16'h0000, '{16'hFFFF, 16'h0000, 16'h8000}, 17'h0, 17'h0,
        0, none},
      '{bts_pkg::OP_SAMPLE, 16'h0, none, 17'h00000, 17'h00000,
        1, '{16'hFFFF, 16'h0000, 16'h8000}},
      '{bts_pkg::OP_WRITE, 16'hFFFF, '{16'h1234, 16'hFFFF, 16'h0001}, 17'h0, 17'h0,
        0, none},
      '{bts_pkg::OP_SAMPLE, 16'h0, none, 17'h10000, 17'h10000,
        1, '{16'h1234, 16'hFFFF, 16'h0001}},
      '{bts_pkg::OP_SAMPLE, 16'hFFFF, none, 17'h1FFFF, 17'h1FFFF,
        1, '{16'h1234, 16'hFFFF, 16'h0001}},
      '{bts_pkg::OP_WRITE, 16'h0001, '{16'hAAAA, 16'h5555, 16'hFFFF}, 17'h0, 17'h0,
        0, none},
      '{bts_pkg::OP_WRITE, 16'h0100, '{16'h5555, 16'hAAAA, 16'h0000}, 17'h0, 17'h0,
        0, none},
      '{bts_pkg::OP_WRITE, 16'h0101, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 17'h0, 17'h0,
        0, none},
      '{bts_pkg::OP_SAMPLE, 16'h0, none, 17'h00080, 17'h00080, 0, none},
      '{bts_pkg::OP_SAMPLE, 16'h0, none, 17'h0FFFF, 17'h0FFFF, 0, none},
      '{bts_pkg::OP_SAMPLE, 16'h0, none, 17'h00100, 17'h10000, 0, none},
      '{bts_pkg::OP_WRITE, 16'hFFFE, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 17'h0, 17'h0,
        0, none},
      '{bts_pkg::OP_SAMPLE, 16'h0, none, 17'h0FFFF, 17'h10000, 0, none}
    };
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.op == bts_pkg::OP_WRITE)
        send_item(bts_pkg::OP_WRITE, row.idx, row.pix, row.u, row.v, 0, none);
      else
        sample_at(row.u, row.v, row.typed, row.want);
    end

    // width/height pairs: extremes, zero, single texel, then random small sizes
    sizes = '{9'd1, 9'd1, 9'd0, 9'd0, 9'd256, 9'd1, 9'd1, 9'd256, 9'd255, 9'd3,
              9'd2, 9'd2, 9'd256, 9'd256};
    repeat (4) begin
      sizes.push_back(9'($urandom_range(2, 16)));
      sizes.push_back(9'($urandom_range(2, 16)));
    end
    for (int p = 0; p < sizes.size(); p += 2) begin
      drain();
      set_reg(bts_pkg::REG_TEX_WIDTH, sizes[p]);
      set_reg(bts_pkg::REG_TEX_HEIGHT, sizes[p + 1]);
      quiet = (p == 8);
      repeat (40) begin
        if ($urandom_range(99) < 30) begin
          pix = rand_rgb();
          send_item(bts_pkg::OP_WRITE, 16'($urandom), pix, 17'($urandom), 17'($urandom),
                    0, none);
        end else begin
          sample_at(rand_coord(), rand_coord(), 0, none);
        end
      end
      quiet = 1'b0;
    end

    drain();
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
